[hdl/lsc_pkg.sv]
// Shared types and constants for the LIFO stack with running checksum.
`timescale 1ns / 1ps

package lsc_pkg;

  localparam int DEPTH      = 1024;
  localparam int VALUE_BITS = 32;
  localparam int ADDR_BITS  = $clog2(DEPTH);
  localparam int CNT_BITS   = $clog2(DEPTH + 1);

  localparam logic       MODE_PUSH = 1'b0;
  localparam logic       MODE_POP  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_OVER  = 2'd1;
  localparam logic [1:0] ST_UNDER = 2'd2;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] push_value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] pop_value;
    logic [1:0]         status;
    logic [10:0]        entry_count;
    logic signed [31:0] checksum;
  } rsp_t;

  // One classified command between the front end and the execution side.
  // pos is the 1-based position touched: the new top on a push, the old top on a pop.
  typedef struct packed {
    logic                  pop;
    logic [1:0]            status;
    logic [CNT_BITS-1:0]   pos;
    logic [CNT_BITS-1:0]   count_after;
    logic [VALUE_BITS-1:0] value;
  } cmd_t;

endpackage

[hdl/lifo_stack_with_checksum.sv]
// Top level of the LIFO stack with running alternating weighted checksum.
//
// Request channel (req_valid, req_stall, req): each beat is a push (mode 0)
// or a pop (mode 1). A beat is taken when req_valid is high and req_stall is
// low. The front end classifies it against its own occupancy count and
// queues it; req_stall rises only when the four-entry command queue is full.
// Response channel (rsp_valid, rsp_stall, rsp): exactly one response beat per
// request beat, in order, carrying the popped word, the status (ok, overflow,
// underflow), the entry count and the checksum after that request.
// A taken request is written into the queue; the execution side then
// handles an overflow or underflow in its accumulate state alone, a push in
// its multiply and accumulate states, and a pop in its memory read, multiply
// and accumulate states, after which rsp_valid rises. A command leaves the
// queue only once the previous response has been taken, so the execution
// side does not start on a new command before the last one is answered.
// A stalled response holds in its output register; the execution side then
// waits, while requests keep being taken until the queue fills.
// Synchronous reset empties the stack, the queue and the checksum; the stack
// memory needs no clearing since only written entries are ever read.
`timescale 1ns / 1ps

module lifo_stack_with_checksum (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  lsc_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output lsc_pkg::rsp_t rsp
);
  import lsc_pkg::*;

  logic q_full;
  logic q_push;
  logic q_pop;
  logic head_valid;
  cmd_t q_data;
  cmd_t head;

  lsc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_data)
  );

  lsc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_data),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  lsc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .q_pop      (q_pop),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp)
  );

endmodule

[hdl/lsc_front.sv]
// Front end: accepts requests, tracks occupancy and classifies each beat.
`timescale 1ns / 1ps

module lsc_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  lsc_pkg::req_t req,
  input  logic          q_full,
  output logic          q_push,
  output lsc_pkg::cmd_t q_data
);
  import lsc_pkg::*;

  logic [CNT_BITS-1:0] count;
  logic [CNT_BITS-1:0] count_next;
  logic                accept;

  assign req_stall = q_full;
  assign accept    = req_valid && !q_full;
  assign q_push    = accept;

  always_comb begin
    q_data.pop         = (req.mode == MODE_POP);
    q_data.value       = VALUE_BITS'(req.push_value);
    q_data.status      = ST_OK;
    q_data.pos         = count;
    count_next         = count;
    if (req.mode == MODE_PUSH) begin
      if (count >= CNT_BITS'(DEPTH)) begin
        q_data.status = ST_OVER;
      end else begin
        count_next = count + CNT_BITS'(1);
        q_data.pos = count_next;
      end
    end else begin
      if (count == '0) begin
        q_data.status = ST_UNDER;
      end else begin
        count_next = count - CNT_BITS'(1);
      end
    end
    q_data.count_after = count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

endmodule

[hdl/lsc_queue.sv]
// Short command queue between the front end and the execution side.
`timescale 1ns / 1ps

module lsc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  lsc_pkg::cmd_t push_data,
  input  logic          pop,
  output logic          full,
  output logic          head_valid,
  output lsc_pkg::cmd_t head
);
  import lsc_pkg::*;

  localparam int QDEPTH = 4;
  localparam int QPTR   = $clog2(QDEPTH);

  cmd_t              slots [QDEPTH];
  logic [QPTR-1:0]   wr_ptr;
  logic [QPTR-1:0]   rd_ptr;
  logic [QPTR:0]     fill;

  assign full       = (fill == (QPTR + 1)'(QDEPTH));
  assign head_valid = (fill != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR'(1);
      end
      if (push && !pop) begin
        fill <= fill + (QPTR + 1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (QPTR + 1)'(1);
      end
    end
  end

endmodule

[hdl/lsc_back.sv]
// Execution side: stack memory, weighted checksum update and result register.
`timescale 1ns / 1ps

module lsc_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  lsc_pkg::cmd_t head,
  output logic          q_pop,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output lsc_pkg::rsp_t rsp
);
  import lsc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_MUL,
    S_ACC
  } state_t;

  state_t                         state;
  cmd_t                           cur;
  logic [VALUE_BITS-1:0]          operand;
  logic [VALUE_BITS-1:0]          product;
  logic [VALUE_BITS-1:0]          checksum;
  logic [VALUE_BITS-1:0]          checksum_next;
  logic [VALUE_BITS-1:0]          rdata;
  logic [VALUE_BITS-1:0]          mem [DEPTH];
  logic [CNT_BITS-1:0]            pos_dec;
  logic [ADDR_BITS-1:0]           addr;
  logic                           mem_we;
  logic [VALUE_BITS+CNT_BITS-1:0] full_prod;
  logic                           subtract;

  assign q_pop   = (state == S_IDLE) && head_valid && !rsp_valid;
  assign pos_dec = head.pos - CNT_BITS'(1);
  assign addr    = pos_dec[ADDR_BITS-1:0];
  assign mem_we  = q_pop && !head.pop && (head.status == ST_OK);

  assign full_prod = {{CNT_BITS{1'b0}}, operand} * {{VALUE_BITS{1'b0}}, cur.pos};

  // Odd positions carry a plus sign; a pop removes the term, so the sign flips.
  assign subtract = cur.pop ^ ~cur.pos[0];

  always_comb begin
    checksum_next = checksum;
    if (cur.status == ST_OK) begin
      if (subtract) begin
        checksum_next = checksum - product;
      end else begin
        checksum_next = checksum + product;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= head.value;
    end
    rdata <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      checksum  <= '0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_pop) begin
            cur     <= head;
            operand <= head.value;
            if (head.status != ST_OK) begin
              state <= S_ACC;
            end else if (head.pop) begin
              state <= S_READ;
            end else begin
              state <= S_MUL;
            end
          end
        end
        S_READ: begin
          operand <= rdata;
          state   <= S_MUL;
        end
        S_MUL: begin
          product <= full_prod[VALUE_BITS-1:0];
          state   <= S_ACC;
        end
        S_ACC: begin
          rsp_valid       <= 1'b1;
          rsp.status      <= cur.status;
          rsp.entry_count <= 11'(cur.count_after);
          rsp.checksum    <= 32'(checksum_next);
          checksum        <= checksum_next;
          if ((cur.status == ST_OK) && cur.pop) begin
            rsp.pop_value <= 32'(operand);
          end else begin
            rsp.pop_value <= '0;
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[test/lsc_checker.sv]
// Checker for the LIFO stack: follows both channels, predicts each response and compares it.
`timescale 1ns / 1ps

module lsc_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_stall,
  input  lsc_pkg::req_t req,
  input  logic          rsp_valid,
  input  logic          rsp_stall,
  input  lsc_pkg::rsp_t rsp,
  output int            fail_count,
  output int            pending,
  output int            checked,
  output int            overflows,
  output int            underflows
);
  import lsc_pkg::*;

  logic [VALUE_BITS-1:0] stack_words [DEPTH];
  int unsigned           depth_now = 0;
  logic [VALUE_BITS-1:0] sum_now = '0;
  rsp_t                  expected_q [$];

  int faults   = 0;
  int compared = 0;
  int n_over   = 0;
  int n_under  = 0;

  assign fail_count = faults;
  assign pending    = expected_q.size();
  assign checked    = compared;
  assign overflows  = n_over;
  assign underflows = n_under;

  // Weighted term of one entry: the position times the value, negated at even positions.
  function automatic logic [VALUE_BITS-1:0] position_term(input int unsigned pos,
                                                          input logic [VALUE_BITS-1:0] v);
    logic [63:0]           prod;
    logic [VALUE_BITS-1:0] term;
    prod = 64'(pos) * 64'(v);
    term = prod[VALUE_BITS-1:0];
    if (pos % 2 == 0) begin
      term = -term;
    end
    return term;
  endfunction

  task automatic apply_request(input req_t r, output rsp_t e);
    logic [VALUE_BITS-1:0] top_word;
    e = '0;
    e.status = ST_OK;
    if (r.mode == MODE_PUSH) begin
      if (depth_now >= DEPTH) begin
        e.status = ST_OVER;
        n_over++;
      end else begin
        stack_words[depth_now] = r.push_value;
        depth_now++;
        sum_now = sum_now + position_term(depth_now, r.push_value);
      end
    end else begin
      if (depth_now == 0) begin
        e.status = ST_UNDER;
        n_under++;
      end else begin
        top_word = stack_words[depth_now - 1];
        sum_now = sum_now - position_term(depth_now, top_word);
        depth_now--;
        e.pop_value = top_word;
      end
    end
    e.entry_count = 11'(depth_now);
    e.checksum = sum_now;
  endtask

  task automatic report_fault(input string msg);
    $display("%0t lsc_checker: %s", $time, msg);
    faults++;
  endtask

  always @(posedge clk) begin
    rsp_t want;
    rsp_t got;
    if (rst) begin
      expected_q.delete();
      depth_now = 0;
      sum_now = '0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        got = rsp;
        if (expected_q.size() == 0) begin
          report_fault($sformatf("response beat %h with nothing outstanding", got));
        end else begin
          want = expected_q.pop_front();
          if (got.pop_value !== want.pop_value)
            report_fault($sformatf("response %0d pop_value %h, expected %h",
                                   compared, got.pop_value, want.pop_value));
          if (got.status !== want.status)
            report_fault($sformatf("response %0d status %0d, expected %0d",
                                   compared, got.status, want.status));
          if (got.entry_count !== want.entry_count)
            report_fault($sformatf("response %0d entry_count %0d, expected %0d",
                                   compared, got.entry_count, want.entry_count));
          if (got.checksum !== want.checksum)
            report_fault($sformatf("response %0d checksum %h, expected %h",
                                   compared, got.checksum, want.checksum));
          compared++;
        end
      end
      if (req_valid && !req_stall) begin
        apply_request(req, want);
        expected_q.push_back(want);
      end
    end
  end

endmodule

[test/tb_lifo_stack_with_checksum.sv]
// Testbench top for the LIFO stack: clock, reset, request and response traffic, verdict.
`timescale 1ns / 1ps

module tb_lifo_stack_with_checksum;
  import lsc_pkg::*;

  localparam int IDLE_LIMIT  = 1500;
  localparam int RANDOM_BEATS = 380;
  localparam int LONG_HOLD   = 200;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  int fail_count;
  int pending;
  int checked;
  int overflows;
  int underflows;

  int sent       = 0;
  int pushes     = 0;
  int pops       = 0;
  int level      = 0;
  int deepest    = 0;
  int idle_count = 0;
  int send_calm  = 0;

  lifo_stack_with_checksum u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  lsc_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked),
    .overflows  (overflows),
    .underflows (underflows)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Wait before a beat: mostly a random pause, with occasional stretches of back-to-back beats.
  function automatic int pick_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      calm = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Entered at a falling edge; returns at the falling edge after the beat was taken.
  task automatic send_beat(input logic m, input logic [31:0] v);
    int gap;
    gap = pick_wait(send_calm);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= '{mode: m, push_value: v};
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sent++;
    if (m == MODE_PUSH) begin
      pushes++;
      if (level < DEPTH) level++;
    end else begin
      pops++;
      if (level > 0) level--;
    end
    if (level > deepest) deepest = level;
    @(negedge clk);
  endtask

  task automatic push_word(input logic [31:0] v);
    send_beat(MODE_PUSH, v);
  endtask

  // The data field of a pop carries noise, which the block must ignore.
  task automatic pop_word();
    send_beat(MODE_POP, $urandom());
  endtask

  // Watchdog: ends the run when no beat moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_count <= 0;
    end else if (idle_count >= IDLE_LIMIT) begin
      $display("tb_lifo_stack_with_checksum: errors");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  // Response side: random stalls per beat, plus one long hold-off so the request queue fills.
  initial begin
    int hold;
    int taken;
    int calm;
    bit held;
    taken = 0;
    calm = 0;
    held = 1'b0;
    rsp_stall = 1'b0;
    wait (rst === 1'b0);
    forever begin
      hold = pick_wait(calm);
      if (taken == 60 && !held) begin
        hold = LONG_HOLD;
        held = 1'b1;
      end
      if (hold > 0) begin
        rsp_stall <= 1'b1;
        repeat (hold) @(negedge clk);
        rsp_stall <= 1'b0;
      end
      @(posedge clk);
      while (!rsp_valid) @(posedge clk);
      taken++;
      @(negedge clk);
    end
  end

  initial begin
    int pick;
    int run;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: pop on empty, extreme words (the checksum wraps), pop all back, pop past empty.
    pop_word();
    push_word(32'h7FFF_FFFF);
    push_word(32'h8000_0000);
    push_word(32'hFFFF_FFFF);
    push_word(32'h0000_0000);
    push_word(32'h0000_0001);
    push_word(32'hAAAA_AAAA);
    push_word(32'h5555_5555);
    push_word(32'h7FFF_FFFF);
    push_word(32'h8000_0000);
    repeat (9) pop_word();
    pop_word();
    pop_word();

    // Random: runs of pushes and runs of pops with random words, plus single odd beats.
    while (sent < 21 + RANDOM_BEATS) begin
      pick = $urandom_range(0, 9);
      run = $urandom_range(1, 16);
      if (pick < 5) begin
        repeat (run) push_word(pick_word());
      end else if (pick < 9) begin
        repeat (run) pop_word();
      end else if ($urandom_range(0, 1) == 0) begin
        push_word(pick_word());
      end else begin
        pop_word();
      end
    end

    // Drain completely and pop past empty once more.
    while (level > 0) pop_word();
    pop_word();
    pop_word();
    req_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("tb_lifo_stack_with_checksum: %0d beats sent (%0d push, %0d pop),",
             sent, pushes, pops);
    $display("tb_lifo_stack_with_checksum: %0d responses checked, deepest %0d of %0d,",
             checked, deepest, DEPTH);
    $display("tb_lifo_stack_with_checksum: %0d overflow, %0d underflow",
             overflows, underflows);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_lifo_stack_with_checksum: clean");
    end else begin
      $display("tb_lifo_stack_with_checksum: errors");
    end
    $finish;
  end

endmodule
